// ===== design/rdc_pkg.sv =====
// Shared types, widths and digit table for the radix digit converter.
`default_nettype none

package rdc_pkg;

    localparam int VALUE_W = 31;
    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W = 7;
    localparam int STEP_W = $clog2(VALUE_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

    localparam logic [CHAR_W-1:0] DIGIT_SET [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    // One queued conversion request.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        logic               is_zero;
    } job_t;

    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] dividend;
        logic [RADIX_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [VALUE_W-1:0] quotient;
        logic [DIGIT_W-1:0] remainder;
    } div_rsp_t;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        return DIGIT_SET[d];
    endfunction

endpackage

`default_nettype wire

// ===== design/rdc_front.sv =====
// Front end: radix register, request intake and classification.
`default_nettype none

module rdc_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [7:0]                  cfg_data,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [rdc_pkg::VALUE_W-1:0] s_value,
    input  wire logic                        q_full,
    output logic                             q_push,
    output rdc_pkg::job_t                    q_job
);

    logic [rdc_pkg::RADIX_W-1:0] radix_reg;
    logic [rdc_pkg::RADIX_W-1:0] radix_next;
    logic [rdc_pkg::RADIX_W-1:0] radix_eff;

    assign cfg_ready = 1'b1;

    always_comb begin
        radix_next = radix_reg;
        if (cfg_valid) begin
            radix_next = cfg_data[rdc_pkg::RADIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= rdc_pkg::RADIX_RESET;
        end else begin
            radix_reg <= radix_next;
        end
    end

    // Out-of-range radix saturates to 2 or 16.
    always_comb begin
        priority if (radix_reg < rdc_pkg::RADIX_MIN) begin
            radix_eff = rdc_pkg::RADIX_MIN;
        end else if (radix_reg > rdc_pkg::RADIX_MAX) begin
            radix_eff = rdc_pkg::RADIX_MAX;
        end else begin
            radix_eff = radix_reg;
        end
    end

    assign s_tready        = !q_full;
    assign q_push          = s_tvalid && !q_full;
    assign q_job.value     = s_value;
    assign q_job.radix     = radix_eff;
    assign q_job.is_zero   = (s_value == '0);

endmodule

`default_nettype wire

// ===== design/rdc_queue.sv =====
// Two-entry request queue between front and back.
`default_nettype none

module rdc_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire rdc_pkg::job_t push_job,
    input  wire logic          pop,
    output rdc_pkg::job_t      head,
    output logic               full,
    output logic               empty
);

    rdc_pkg::job_t entry_reg [rdc_pkg::QUEUE_DEPTH];
    logic [rdc_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [rdc_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [rdc_pkg::QCNT_W-1:0] count_reg;
    logic [rdc_pkg::QCNT_W-1:0] count_next;
    logic do_push;
    logic do_pop;

    assign full    = (count_reg == rdc_pkg::QCNT_W'(rdc_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== design/rdc_divider.sv =====
// Bit-serial restoring divider: 31-bit dividend by a radix of 2 to 16.
`default_nettype none

module rdc_divider (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rdc_pkg::div_req_t req,
    output rdc_pkg::div_rsp_t      rsp
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [rdc_pkg::STEP_W-1:0]    step_reg;
    logic [rdc_pkg::VALUE_W-1:0]   quo_reg;
    logic [rdc_pkg::VALUE_W-1:0]   quo_next;
    logic [rdc_pkg::DIGIT_W-1:0]   rem_reg;
    logic [rdc_pkg::DIGIT_W-1:0]   rem_next;
    logic [rdc_pkg::DIGIT_W:0]     shifted;
    logic                          geq;

    // Remainder stays below the divisor, so 4 bits plus the incoming bit suffice.
    always_comb begin
        shifted  = {rem_reg, quo_reg[rdc_pkg::VALUE_W-1]};
        geq      = (shifted >= req.divisor);
        rem_next = geq ? rdc_pkg::DIGIT_W'(shifted - req.divisor)
                       : shifted[rdc_pkg::DIGIT_W-1:0];
        quo_next = {quo_reg[rdc_pkg::VALUE_W-2:0], geq};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= busy_reg && (step_reg == '0);
            if (busy_reg) begin
                quo_reg  <= quo_next;
                rem_reg  <= rem_next;
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                end
            end else if (req.start) begin
                busy_reg <= 1'b1;
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                step_reg <= rdc_pkg::STEP_W'(rdc_pkg::VALUE_W - 1);
            end
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

// ===== design/rdc_back.sv =====
// Back end: digit generation sequencer, digit store and output register.
`default_nettype none

module rdc_back #(
    parameter int MAX_DIGITS = 31
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_empty,
    input  wire rdc_pkg::job_t     q_head,
    output logic                   q_pop,
    output rdc_pkg::div_req_t      div_req,
    input  wire rdc_pkg::div_rsp_t div_rsp,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_OUT
    } state_t;

    state_t                          state_reg;
    logic [rdc_pkg::VALUE_W-1:0]     quot_reg;
    logic [rdc_pkg::RADIX_W-1:0]     radix_reg;
    logic [CNT_W-1:0]                count_reg;
    logic [IDX_W-1:0]                rd_idx_reg;
    logic                            start_reg;
    logic                            out_valid_reg;
    logic [rdc_pkg::CHAR_W-1:0]      out_char_reg;
    logic                            out_last_reg;

    logic [rdc_pkg::DIGIT_W-1:0]     digit_store [MAX_DIGITS];
    logic [rdc_pkg::DIGIT_W-1:0]     rd_data_reg;
    logic                            wr_en;
    logic [IDX_W-1:0]                wr_idx;
    logic [rdc_pkg::DIGIT_W-1:0]     wr_data;
    logic                            more_digits;
    logic                            out_free;

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign out_free = !out_valid_reg || m_tready;

    assign more_digits = (div_rsp.quotient != '0)
                      && ((count_reg + 1'b1) != CNT_W'(MAX_DIGITS));

    // Zero skips the divider and stores a single zero digit.
    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = count_reg[IDX_W-1:0];
        wr_data = div_rsp.remainder;
        if (q_pop && q_head.is_zero) begin
            wr_en   = 1'b1;
            wr_idx  = '0;
            wr_data = '0;
        end else if ((state_reg == ST_DIV) && div_rsp.done) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            digit_store[wr_idx] <= wr_data;
        end
        rd_data_reg <= digit_store[rd_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
        end else begin
            // Kick the divider on a nonzero pop or when more digits remain
            start_reg <= (q_pop && !q_head.is_zero)
                      || ((state_reg == ST_DIV) && div_rsp.done && more_digits);
            if (out_valid_reg && m_tready && (state_reg != ST_OUT)) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        quot_reg   <= q_head.value;
                        radix_reg  <= q_head.radix;
                        count_reg  <= '0;
                        rd_idx_reg <= '0;
                        if (q_head.is_zero) begin
                            state_reg <= ST_RD;
                        end else begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        quot_reg <= div_rsp.quotient;
                        if (more_digits) begin
                            count_reg <= count_reg + 1'b1;
                        end else begin
                            rd_idx_reg <= count_reg[IDX_W-1:0];
                            state_reg  <= ST_RD;
                        end
                    end
                end
                ST_RD: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    out_valid_reg <= !out_free;
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_char_reg  <= rdc_pkg::digit_to_char(rd_data_reg);
                        out_last_reg  <= (rd_idx_reg == '0);
                        if (rd_idx_reg == '0) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            rd_idx_reg <= rd_idx_reg - 1'b1;
                            state_reg  <= ST_RD;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign div_req.start    = start_reg;
    assign div_req.dividend = quot_reg;
    assign div_req.divisor  = radix_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== design/radix_digit_converter_unit.sv =====
// Top level of the radix digit converter: integer to ASCII digits in base 2..16.
// Each digit costs one pass of the bit-serial divider plus a registered handoff
//   (done, then start); emission then replays each stored digit through the
//   ST_RD and ST_OUT states. A zero request skips the divider.
// Throughput: one request at a time in the back end, set by the shared divider;
//   a two-deep queue lets the front take up to two more requests meanwhile.
// Reset (aresetn, sync, active low): radix returns to 10, queue, sequencer and
//   output register clear; the digit store is not cleared.
`default_nettype none

module radix_digit_converter_unit #(
    parameter int MAX_DIGITS = 31
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // Radix register write channel; cfg_data[4:0] = radix
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data,
    // Request channel
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [31:0] s_tdata,   // [30:0] value, [31] zero pad
    // Digit channel
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // [6:0] digit_char, [7] zero pad
    output logic            m_tlast     // last_digit
);

    // Front to queue
    logic              q_push;
    rdc_pkg::job_t     q_job;
    // Queue to back
    logic              q_pop;
    rdc_pkg::job_t     q_head;
    logic              q_full;
    logic              q_empty;
    // Back <-> divider
    rdc_pkg::div_req_t div_req;
    rdc_pkg::div_rsp_t div_rsp;

    // Front: holds radix, saturates it, tags zero requests
    rdc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_value   (s_tdata[rdc_pkg::VALUE_W-1:0]),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    // Decoupling queue; radix travels with each request
    rdc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Shared divider: one quotient bit per cycle while busy
    rdc_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Back: collects remainders LSD first, replays them MSD first
    rdc_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Output register and divider come out of reset idle
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !div_rsp.busy)
        else $error("output or divider active after reset");

    // Back only pulls from a non-empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("pop from empty request queue");

    // Divider completion is a single-cycle pulse after a busy pass
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> $past(div_rsp.busy))
        else $error("divider done without a pass");

    // No new division may be started while one is running
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

endmodule

`default_nettype wire
